// ===== rtl/pcf_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer package
// Shared types, constants and CRC-32 helpers for the chunk framer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam int unsigned LEN_W  = 31;
   localparam int unsigned STEP_W = 4;

   // byte positions of a framed chunk
   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_W-1:0] STEP_TYPE  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DATA  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CRC   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_LAST  = 4'd11;

   localparam logic [1:0] KIND_IHDR = 2'd0;
   localparam logic [1:0] KIND_IDAT = 2'd1;
   localparam logic [1:0] KIND_IEND = 2'd2;

   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_R = 8'h52;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_N = 8'h4E;

   typedef enum logic [1:0] {
      OP_HDR,
      OP_HDR_CRC,
      OP_DATA,
      OP_DATA_CRC
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [1:0]       kind;
      logic [LEN_W-1:0] len;
      logic [7:0]       data;
      logic [31:0]      crc;
   } cmd_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] type_char(input logic [1:0] kind, input logic [1:0] idx);
      logic [7:0] ch;
      ch = CHAR_I;
      case (idx)
         2'd0: ch = CHAR_I;
         2'd1: begin
            case (kind)
               KIND_IHDR: ch = CHAR_H;
               KIND_IDAT: ch = CHAR_D;
               default:   ch = CHAR_E;
            endcase
         end
         2'd2: begin
            case (kind)
               KIND_IHDR: ch = CHAR_D;
               KIND_IDAT: ch = CHAR_A;
               default:   ch = CHAR_N;
            endcase
         end
         default: begin
            case (kind)
               KIND_IHDR: ch = CHAR_R;
               KIND_IDAT: ch = CHAR_T;
               default:   ch = CHAR_D;
            endcase
         end
      endcase
      return ch;
   endfunction

   function automatic logic [31:0] type_crc(input logic [1:0] kind);
      logic [31:0] c;
      c = CRC_INIT;
      for (int i = 0; i < 4; i++) begin
         c = crc_byte(c, type_char(kind, 2'(i)));
      end
      return c;
   endfunction

   // running CRC after the four type bytes, per chunk kind
   localparam logic [31:0] TYPE_CRC [4] = '{
      type_crc(2'd0), type_crc(2'd1), type_crc(2'd2), type_crc(2'd3)
   };

endpackage

`default_nettype wire

// ===== rtl/pcf_front.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer front end
// Classifies accepted transactions, tracks chunk state and the running CRC,
// and issues one command per transaction that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic                     mode,
   input  wire logic [1:0]               chunk_kind,
   input  wire logic [pcf_pkg::LEN_W-1:0] payload_length,
   input  wire logic [7:0]               data_byte,
   output      logic                     cmd_valid,
   output      pcf_pkg::cmd_type         cmd
);

   logic [31:0]               crc_ff,  crc_in;
   logic [pcf_pkg::LEN_W-1:0] left_ff, left_in;
   logic                      open_ff, open_in;
   logic [31:0]               crc_next;
   logic                      len_zero;
   logic                      last_byte;

   assign crc_next  = pcf_pkg::crc_byte(crc_ff, data_byte);
   assign len_zero  = (payload_length == '0);
   assign last_byte = (left_ff == pcf_pkg::LEN_W'(1));

   always_comb begin
      crc_in    = crc_ff;
      left_in   = left_ff;
      open_in   = open_ff;
      cmd_valid = 1'b0;
      cmd.op    = pcf_pkg::OP_HDR;
      cmd.kind  = chunk_kind;
      cmd.len   = payload_length;
      cmd.data  = data_byte;
      cmd.crc   = ~pcf_pkg::TYPE_CRC[chunk_kind];
      if (accept) begin
         if (!mode) begin
            cmd_valid = 1'b1;
            left_in   = payload_length;
            if (len_zero) begin
               cmd.op  = pcf_pkg::OP_HDR_CRC;
               crc_in  = pcf_pkg::CRC_INIT;
               open_in = 1'b0;
            end else begin
               crc_in  = pcf_pkg::TYPE_CRC[chunk_kind];
               open_in = 1'b1;
            end
         end else if (open_ff) begin
            cmd_valid = 1'b1;
            cmd.crc   = ~crc_next;
            left_in   = left_ff - pcf_pkg::LEN_W'(1);
            if (last_byte) begin
               cmd.op  = pcf_pkg::OP_DATA_CRC;
               crc_in  = pcf_pkg::CRC_INIT;
               open_in = 1'b0;
            end else begin
               cmd.op  = pcf_pkg::OP_DATA;
               crc_in  = crc_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= pcf_pkg::CRC_INIT;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pcf_queue.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer command queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_queue #(
   parameter int unsigned DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire pcf_pkg::cmd_type wr_cmd,
   input  wire logic             rd_en,
   output pcf_pkg::cmd_type      rd_cmd,
   output      logic             q_empty,
   output      logic             q_full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

   pcf_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pcf_back.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer back end
// Walks each command through its output bytes into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcf_pkg::cmd_type  head,
   input  wire logic              head_valid,
   output      logic              head_pop,
   input  wire logic              pop,
   output      logic              empty,
   output      logic [7:0]        out_byte,
   output      logic              chunk_done,
   output      logic              run_last
);

   logic [pcf_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       active_ff, active_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       done_ff, done_in;
   logic                       last_ff, last_in;
   logic [pcf_pkg::STEP_W-1:0] cur_step;
   logic [pcf_pkg::STEP_W-1:0] end_step;
   logic [pcf_pkg::STEP_W-1:0] start_step;
   logic                       is_data;
   logic                       load;
   logic                       emit;
   logic                       at_end;
   logic [7:0]                 sel_byte;

   always_comb begin
      case (head.op) inside
         pcf_pkg::OP_DATA, pcf_pkg::OP_DATA_CRC: is_data = 1'b1;
         default:                                is_data = 1'b0;
      endcase
      case (head.op) inside
         pcf_pkg::OP_HDR, pcf_pkg::OP_DATA: end_step = pcf_pkg::STEP_DATA;
         default:                           end_step = pcf_pkg::STEP_LAST;
      endcase
   end

   assign start_step = is_data ? pcf_pkg::STEP_DATA : pcf_pkg::STEP_FIRST;
   assign cur_step   = active_ff ? step_ff : start_step;
   assign at_end     = (cur_step == end_step);
   assign load       = !valid_ff || pop;
   assign emit       = load && head_valid;
   assign head_pop   = emit && at_end;

   always_comb begin
      case (cur_step)
         4'd0:    sel_byte = {1'b0, head.len[30:24]};
         4'd1:    sel_byte = head.len[23:16];
         4'd2:    sel_byte = head.len[15:8];
         4'd3:    sel_byte = head.len[7:0];
         4'd4:    sel_byte = pcf_pkg::type_char(head.kind, 2'd0);
         4'd5:    sel_byte = pcf_pkg::type_char(head.kind, 2'd1);
         4'd6:    sel_byte = pcf_pkg::type_char(head.kind, 2'd2);
         4'd7:    sel_byte = is_data ? head.data : pcf_pkg::type_char(head.kind, 2'd3);
         4'd8:    sel_byte = head.crc[31:24];
         4'd9:    sel_byte = head.crc[23:16];
         4'd10:   sel_byte = head.crc[15:8];
         default: sel_byte = head.crc[7:0];
      endcase
   end

   always_comb begin
      step_in   = step_ff;
      active_in = active_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      done_in   = done_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = emit;
      end
      if (emit) begin
         byte_in = sel_byte;
         done_in = (cur_step == pcf_pkg::STEP_LAST);
         last_in = at_end;
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            step_in   = cur_step + pcf_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= pcf_pkg::STEP_FIRST;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      done_ff <= done_in;
      last_ff <= last_in;
   end

   assign empty      = !valid_ff;
   assign out_byte   = byte_ff;
   assign chunk_done = done_ff;
   assign run_last   = last_ff;

endmodule

`default_nettype wire

// ===== rtl/png_chunk_framer.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer
// Frames PNG chunks (length, type, payload, CRC-32) as a byte stream.
// ----------------------------------------------------------------------------
// A start transaction yields 8 output bytes (12 for zero length).
// Throughput: one result byte per cycle out of the result register while pop
// is held and commands wait; a data transaction is accepted every cycle
// while the command queue has room.
// Reset clears chunk state, the CRC to all ones, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_framer #(
   parameter int unsigned QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output      logic                      full,
   input  wire logic                      req_mode,
   input  wire logic [1:0]                req_chunk_kind,
   input  wire logic [pcf_pkg::LEN_W-1:0] req_payload_length,
   input  wire logic [7:0]                req_data_byte,
   output      logic                      empty,
   input  wire logic                      pop,
   output      logic [7:0]                rsp_out_byte,
   output      logic                      rsp_chunk_done,
   output      logic                      rsp_run_last
);

   logic             accept;
   logic             cmd_valid;
   pcf_pkg::cmd_type cmd;
   pcf_pkg::cmd_type head;
   logic             q_empty;
   logic             q_full;
   logic             head_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   pcf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .mode           (req_mode),
      .chunk_kind     (req_chunk_kind),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd)
   );

   pcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_cmd  (cmd),
      .rd_en   (head_pop),
      .rd_cmd  (head),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   pcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_empty),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .chunk_done (rsp_chunk_done),
      .run_last   (rsp_run_last)
   );

endmodule

`default_nettype wire

// ===== rtl/pcf_checker.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer checker
// Port-level properties of the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_chunk_done,
   input wire logic       rsp_run_last
);

   // final CRC byte always ends the transaction's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_chunk_done) |-> rsp_run_last)
      else $error("chunk_done without run_last");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result visible right after reset");

   a_room_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !full)
      else $error("full right after reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_run_last)))
      else $error("waiting transaction changed");

endmodule

bind png_chunk_framer pcf_checker u_pcf_checker (
   .clock          (clock),
   .reset          (reset),
   .full           (full),
   .empty          (empty),
   .pop            (pop),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_chunk_done (rsp_chunk_done),
   .rsp_run_last   (rsp_run_last)
);

`default_nettype wire
